@@ src/kpc_pkg.sv @@
// ----------------------------------------------------------------------------
// kpc_pkg: shared definitions for the key press classifier
// Register codes, reset values and widths used across the block.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // counter and register width
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // register reset values
  localparam logic [CntW-1:0] LongPressRst = 8'd200;
  localparam logic [CntW-1:0] MinPressRst  = 8'd5;
  localparam logic [CntW-1:0] GapLowRst    = 8'd10;
  localparam logic [CntW-1:0] GapHighRst   = 8'd50;

  // click run value that fires the command pulse
  localparam logic [CntW-1:0] CmdRun = 8'd2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LONG_PRESS = 8'd0,
    REG_MIN_PRESS  = 8'd1,
    REG_GAP_LOW    = 8'd2,
    REG_GAP_HIGH   = 8'd3
  } cfg_reg_t;

  // one classified tick
  typedef struct packed {
    logic            long_press;
    logic            short_press;
    logic            press_rejected;
    logic            multi_click;
    logic [CntW-1:0] click_run;
    logic            command_trigger;
  } kpc_result_t;

endpackage

@@ src/key_press_classifier.sv @@
// ----------------------------------------------------------------------------
// key_press_classifier: short / long / multi-click detector for one key
// Classifies one tick request per cycle while in_stall is low and registers the result.
// ----------------------------------------------------------------------------
// A result appears in the cycle after its tick request is accepted.
// Throughput: one tick per cycle; the result register refills in the cycle
// it is taken, so in_stall rises only while an unread result is stalled.
// Reset (rst_n low, synchronous): all classifier state cleared, registers
// back to 200 / 5 / 10 / 50, no result pending.
module key_press_classifier
  import kpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_wdata,
  // tick requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_press_edge,
  input  logic               in_key_down,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_long_press,
  output logic               out_short_press,
  output logic               out_press_rejected,
  output logic               out_multi_click,
  output logic [CntW-1:0]    out_click_run,
  output logic               out_command_trigger
);

  // configuration registers
  logic [CntW-1:0] long_ticks_r, min_ticks_r, gap_low_r, gap_high_r;

  // classifier state
  logic            armed_r, armed_nxt;
  logic [CntW-1:0] hold_r, hold_nxt;
  logic            gap_run_r, gap_run_nxt;
  logic [CntW-1:0] gap_r, gap_nxt;
  logic [CntW-1:0] run_r, run_nxt;
  logic            multi_r, multi_nxt;

  // result register
  logic            out_valid_r;
  kpc_result_t     res_r, res_nxt;

  logic            in_accept;
  logic            armed_now;
  logic [CntW-1:0] gap_step;

  // handshake: the result register refills whenever it is empty or drained
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign armed_now = armed_r | in_press_edge;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LongPressRst;
      min_ticks_r  <= MinPressRst;
      gap_low_r    <= GapLowRst;
      gap_high_r   <= GapHighRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS: long_ticks_r <= cfg_wdata;
        REG_MIN_PRESS:  min_ticks_r  <= cfg_wdata;
        REG_GAP_LOW:    gap_low_r    <= cfg_wdata;
        REG_GAP_HIGH:   gap_high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick classification
  always_comb begin
    armed_nxt   = armed_now;
    hold_nxt    = hold_r;
    gap_run_nxt = gap_run_r;
    run_nxt     = run_r;
    multi_nxt   = multi_r;
    res_nxt     = '0;

    if (armed_now) begin
      if (in_key_down) begin
        if (hold_r < long_ticks_r) begin
          hold_nxt = hold_r + 1'b1;
        end else begin
          // long press limit reached
          hold_nxt           = '0;
          res_nxt.long_press = 1'b1;
          armed_nxt          = 1'b0;
        end
      end else if (hold_r > min_ticks_r) begin
        hold_nxt            = '0;
        res_nxt.short_press = 1'b1;
        armed_nxt           = 1'b0;
        // gap strictly inside the window chains the click
        if (gap_r > gap_low_r && gap_r < gap_high_r) begin
          if (run_r != CntMax) begin
            run_nxt                 = run_r + 1'b1;
            res_nxt.command_trigger = (run_nxt == CmdRun);
          end
          multi_nxt = 1'b1;
        end else begin
          multi_nxt = 1'b0;
          run_nxt   = '0;
        end
        gap_run_nxt = 1'b1;
      end else begin
        // glitch: released too soon
        hold_nxt               = '0;
        res_nxt.press_rejected = 1'b1;
        multi_nxt              = 1'b0;
        armed_nxt              = 1'b0;
      end
    end

    // gap counter, saturating, cleared at the window's upper end
    gap_step = (gap_run_nxt && gap_r != CntMax) ? gap_r + 1'b1 : gap_r;
    gap_nxt  = gap_step;
    if (gap_step >= gap_high_r) begin
      gap_nxt     = '0;
      gap_run_nxt = 1'b0;
      multi_nxt   = 1'b0;
      run_nxt     = '0;
    end

    res_nxt.multi_click = multi_nxt;
    res_nxt.click_run   = run_nxt;
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      hold_r    <= '0;
      gap_run_r <= 1'b0;
      gap_r     <= '0;
      run_r     <= '0;
      multi_r   <= 1'b0;
    end else if (in_accept) begin
      armed_r   <= armed_nxt;
      hold_r    <= hold_nxt;
      gap_run_r <= gap_run_nxt;
      gap_r     <= gap_nxt;
      run_r     <= run_nxt;
      multi_r   <= multi_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_long_press      = res_r.long_press;
  assign out_short_press     = res_r.short_press;
  assign out_press_rejected  = res_r.press_rejected;
  assign out_multi_click     = res_r.multi_click;
  assign out_click_run       = res_r.click_run;
  assign out_command_trigger = res_r.command_trigger;

  // checks
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({res_r.long_press, res_r.short_press, res_r.press_rejected}))
    else $error("more than one press event in one result");

  // the run may already be cleared by the window end in the same tick
  a_cmd_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.command_trigger) |->
      (res_r.short_press &&
       ((res_r.multi_click && res_r.click_run == CmdRun) ||
        (!res_r.multi_click && res_r.click_run == '0))))
    else $error("command pulse without a two-click run");

  a_run_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (res_r.click_run == run_r && res_r.multi_click == multi_r))
    else $error("result run does not match classifier state");

  a_disarm_on_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (res_nxt.long_press || res_nxt.short_press || res_nxt.press_rejected))
      |=> (!armed_r && hold_r == '0))
    else $error("classifier still armed after a press event");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result pending after reset");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for key_press_classifier
// A queue of key tick requests feeds a bursty driver; every accepted tick is
// classified by a local model of the hold, gap and click-run counters and
// the predicted result is compared with what the block returns, while the
// result side stalls on changing patterns.
// ----------------------------------------------------------------------------
module testbench
  import kpc_pkg::*;
();

  localparam int RandomTicks = 150;
  localparam int PhaseTicks  = 50;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;

  // indexes past the last register, writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegIdxAbove = 8'd4;
  localparam logic [CfgIdxW-1:0] RegIdxTop   = 8'hFF;

  typedef struct packed {
    logic press_edge;
    logic key_down;
  } tick_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CntW-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_press_edge = 1'b0;
  logic               in_key_down = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_long_press;
  logic               out_short_press;
  logic               out_press_rejected;
  logic               out_multi_click;
  logic [CntW-1:0]    out_click_run;
  logic               out_command_trigger;

  key_press_classifier uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_press_edge       (in_press_edge),
    .in_key_down         (in_key_down),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_long_press      (out_long_press),
    .out_short_press     (out_short_press),
    .out_press_rejected  (out_press_rejected),
    .out_multi_click     (out_multi_click),
    .out_click_run       (out_click_run),
    .out_command_trigger (out_command_trigger)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // pending tick requests and predicted results
  tick_t       pending_ticks[$];
  kpc_result_t predicted_results[$];

  // local copy of the classifier registers
  logic [CntW-1:0] hold_limit = LongPressRst;
  logic [CntW-1:0] min_hold   = MinPressRst;
  logic [CntW-1:0] gap_low    = GapLowRst;
  logic [CntW-1:0] gap_high   = GapHighRst;

  // local copy of the classifier state
  logic            armed_q  = 1'b0;
  logic [CntW-1:0] hold_cnt = '0;
  logic            gap_on   = 1'b0;
  logic [CntW-1:0] gap_cnt  = '0;
  logic [CntW-1:0] run_cnt  = '0;
  logic            multi_q  = 1'b0;

  // settings the stimulus is shaped for
  int plan_long = LongPressRst;
  int plan_min  = MinPressRst;
  int plan_low  = GapLowRst;
  int plan_high = GapHighRst;

  int pushed_ticks = 0;
  int ticks_sent   = 0;
  int results_seen = 0;
  int settings     = 1;
  int mismatches   = 0;
  int n_long = 0, n_short = 0, n_reject = 0, n_cmd = 0, n_multi = 0;
  int burst_left = 0, gap_left = 0;
  int stall_cycle = 0, stall_mode = 0;
  int idle_cycles = 0;

  // one tick of the classifier: arm, classify the hold, then run the gap
  function automatic kpc_result_t classify_tick(input logic pe, input logic kd);
    kpc_result_t r;
    r = '0;
    if (pe) armed_q = 1'b1;
    if (armed_q) begin
      if (kd) begin
        if (hold_cnt < hold_limit) begin
          hold_cnt = hold_cnt + 1'b1;
        end else begin
          hold_cnt = '0;
          r.long_press = 1'b1;
          armed_q = 1'b0;
        end
      end else if (hold_cnt > min_hold) begin
        hold_cnt = '0;
        r.short_press = 1'b1;
        armed_q = 1'b0;
        if (gap_cnt > gap_low && gap_cnt < gap_high) begin
          if (run_cnt != CntMax) begin
            run_cnt = run_cnt + 1'b1;
            if (run_cnt == CmdRun) r.command_trigger = 1'b1;
          end
          multi_q = 1'b1;
        end else begin
          multi_q = 1'b0;
          run_cnt = '0;
        end
        gap_on = 1'b1;
      end else begin
        // released too soon: glitch, run count kept
        hold_cnt = '0;
        r.press_rejected = 1'b1;
        multi_q = 1'b0;
        armed_q = 1'b0;
      end
    end
    if (gap_on && gap_cnt != CntMax) gap_cnt = gap_cnt + 1'b1;
    if (gap_cnt >= gap_high) begin
      gap_cnt = '0;
      gap_on = 1'b0;
      multi_q = 1'b0;
      run_cnt = '0;
    end
    r.multi_click = multi_q;
    r.click_run = run_cnt;
    return r;
  endfunction

  function automatic string fmt_result(input kpc_result_t r);
    return $sformatf("lp=%0b sp=%0b rej=%0b multi=%0b run=%0d cmd=%0b", r.long_press,
                     r.short_press, r.press_rejected, r.multi_click, r.click_run,
                     r.command_trigger);
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // register writes seen by the block update the local copy
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS: hold_limit <= cfg_wdata;
        REG_MIN_PRESS:  min_hold <= cfg_wdata;
        REG_GAP_LOW:    gap_low <= cfg_wdata;
        REG_GAP_HIGH:   gap_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // driver: bursts of tick requests with random gaps
  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_press_edge <= 1'b0;
      in_key_down <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(classify_tick(in_press_edge, in_key_down));
        ticks_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          in_valid <= 1'b1;
          in_press_edge <= nxt.press_edge;
          in_key_down <= nxt.key_down;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result, stall on a changing pattern
  always @(posedge clk) begin : check_results
    kpc_result_t got;
    kpc_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.long_press = out_long_press;
        got.short_press = out_short_press;
        got.press_rejected = out_press_rejected;
        got.multi_click = out_multi_click;
        got.click_run = out_click_run;
        got.command_trigger = out_command_trigger;
        results_seen++;
        n_long += got.long_press;
        n_short += got.short_press;
        n_reject += got.press_rejected;
        n_cmd += got.command_trigger;
        n_multi += got.multi_click;
        if (predicted_results.size() == 0) begin
          note_mismatch({"unexpected result: ", fmt_result(got)});
        end else begin
          want = predicted_results.pop_front();
          if (got !== want)
            note_mismatch({"result mismatch, expected ", fmt_result(want),
                           " got ", fmt_result(got)});
        end
      end
      stall_cycle++;
      if (stall_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_cycle % 3 == 0);
      endcase
    end
  end

  // watchdog: no progress while work is pending
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_ticks.size() == 0 && !in_valid && predicted_results.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d requests pending, %0d results outstanding",
                 pending_ticks.size(), predicted_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_tick(input logic pe, input logic kd);
    tick_t t;
    t.press_edge = pe;
    t.key_down = kd;
    pending_ticks.push_back(t);
    pushed_ticks++;
  endtask

  // one press: edge with the first held tick (a bare edge if hold is 0), release, then key-up ticks
  task automatic push_press(input int hold, input int gap, input bit extra_edge);
    if (hold == 0) begin
      push_tick(1'b1, 1'b0);
    end else begin
      for (int i = 0; i < hold; i++)
        push_tick(i == 0 || (extra_edge && i == hold / 2), 1'b1);
      push_tick(1'b0, 1'b0);
    end
    repeat (gap) push_tick(1'b0, 1'b0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CntW-1:0];
  endtask

  task automatic set_config(input int lp, input int mn, input int lo, input int hi);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_MIN_PRESS, mn);
    write_reg(REG_GAP_LOW, lo);
    write_reg(REG_GAP_HIGH, hi);
    write_reg($urandom_range(0, 1) ? RegIdxAbove : RegIdxTop, $urandom_range(0, 255));
    @(posedge clk);
    cfg_we <= 1'b0;
    plan_long = lp;
    plan_min = mn;
    plan_low = lo;
    plan_high = hi;
    settings++;
  endtask

  // hold off until every request is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // random sequence, mostly well-formed presses sized to the current window
  task automatic push_random_sequence();
    int kind, hold, gap, span;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 4))
        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      if (kind < 5) begin
        hold = $urandom_range(0, plan_min);
      end else if (kind < 17) begin
        span = (plan_long > plan_min + 1) ? plan_long - plan_min - 1 : 0;
        hold = plan_min + 1 + $urandom_range(0, span);
      end else begin
        hold = plan_long + 1 + $urandom_range(0, 3);
      end
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, plan_high + 2);
      push_press(hold, gap, $urandom_range(0, 7) == 0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    int random_ticks, phase_start, lp, mn, lo, hi;
    random_ticks = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: short press, chained press, glitch
    push_press(7, 12, 1'b0);
    push_press(7, 0, 1'b0);
    push_press(3, 3, 1'b0);
    wait_idle();

    // small window: glitch on bare edge, click run to the command pulse,
    // glitch keeping the run, long press with an extra press edge while armed
    set_config(4, 1, 1, 12);
    push_press(0, 0, 1'b0);
    push_press(2, 2, 1'b0);
    push_press(2, 0, 1'b0);
    push_press(2, 0, 1'b0);
    push_press(1, 0, 1'b0);
    push_press(5, 4, 1'b1);
    wait_idle();

    // zero long-press limit and zero window end
    set_config(0, 0, 0, 0);
    push_press(1, 0, 1'b0);
    push_press(0, 0, 1'b0);
    push_press(3, 1, 1'b0);
    wait_idle();
    set_config(1, 0, 0, 0);
    push_press(1, 1, 1'b0);
    push_press(2, 1, 1'b0);
    wait_idle();

    // registers at or next to the top: full-length short press
    set_config(255, 254, 255, 255);
    push_press(255, 3, 1'b0);
    wait_idle();

    // random phases, each under its own register setting
    while (random_ticks < RandomTicks) begin
      lp = $urandom_range(1, 24);
      mn = $urandom_range(0, 5);
      lo = $urandom_range(0, 6);
      hi = lo + $urandom_range(1, 30);
      case ($urandom_range(0, 7))
        0: hi = $urandom_range(0, 3);
        1: lp = $urandom_range(0, 2);
        default: ;
      endcase
      set_config(lp, mn, lo, hi);
      phase_start = pushed_ticks;
      while (pushed_ticks - phase_start < PhaseTicks) push_random_sequence();
      random_ticks += pushed_ticks - phase_start;
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d ticks / %0d results under %0d register settings", ticks_sent,
             results_seen, settings);
    $display("Seen: %0d short, %0d long, %0d rejected, %0d command, %0d multi-click ticks",
             n_short, n_long, n_reject, n_cmd, n_multi);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
